/* rtl/tcdr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcdr_pkg
// Shared types, constants and helpers for the click delay / repeat filter.
// ----------------------------------------------------------------------------
package tcdr_pkg;

    localparam int CacheDepth = 16;
    localparam int IdxW       = $clog2(CacheDepth);
    localparam int CntW       = $clog2(CacheDepth + 1);
    localparam int TimeW      = 48;
    localparam logic [TimeW-1:0] TimeMax = '1;
    localparam logic [33:0] SlopSq = 34'd64;

    localparam logic [2:0] KIND_DOWN   = 3'd0;
    localparam logic [2:0] KIND_MOVE   = 3'd1;
    localparam logic [2:0] KIND_UP     = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd4;
    localparam logic [2:0] KIND_TICK   = 3'd5;

    localparam logic [1:0] REG_RESPONSE = 2'd0;
    localparam logic [1:0] REG_IGN_EN   = 2'd1;
    localparam logic [1:0] REG_IGN_LVL  = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [4:0]  fc;
        logic [15:0] x;
        logic [15:0] y;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input, run decision
        logic emit_in;    // show input event
        logic emit_rep;   // show cache entry at scan index
        logic emit_up;    // show input up (scan matched)
        logic scan_step;  // advance scan index
        logic shift_step; // pull next entry into scan slot, advance
        logic drop;       // cache count minus one
        logic last;
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_EMIT  = 3'd1,
        OP_REPLAY = 3'd2,
        OP_REPLAY_MOVE = 3'd3,
        OP_UPSCAN = 3'd4,
        OP_REMOVE = 3'd5
    } op_t;

    // datapath -> controller
    typedef struct packed {
        op_t        op;
        logic       scan_done;  // scan index reached end
        logic       scan_hit;   // current entry id equals input id
        logic       rest_hit;   // any match at or after scan index
        logic       more_hit;   // any match after scan index
        logic       scan_last;  // scan index is the final entry
    } stat_t;

    function automatic logic [TimeW-1:0] resp_delay(input logic [1:0] lvl);
        case (lvl)
            2'd1:    resp_delay = TimeW'(300_000);
            2'd2:    resp_delay = TimeW'(600_000);
            default: resp_delay = '0;
        endcase
    endfunction

    function automatic logic [TimeW-1:0] ign_window(input logic [2:0] lvl);
        case (lvl)
            3'd1:    ign_window = TimeW'(400_000);
            3'd2:    ign_window = TimeW'(700_000);
            3'd3:    ign_window = TimeW'(1_000_000);
            3'd4:    ign_window = TimeW'(1_300_000);
            default: ign_window = TimeW'(100_000);
        endcase
    endfunction

endpackage
`default_nettype wire

/* rtl/tcdr_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcdr_datapath
// Filter state, down cache, decision logic and output register.
// ----------------------------------------------------------------------------
module tcdr_datapath import tcdr_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [2:0]        cfg_data,
    input  wire logic [2:0]        kind,
    input  wire logic [7:0]        pointer_id,
    input  wire logic [4:0]        finger_count,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic [TimeW-1:0]  time_us,
    input  wire logic              is_knuckle,
    input  wire logic              is_touchscreen,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    output logic [2:0]             out_action,
    output logic [7:0]             out_pointer_id,
    output logic [4:0]             out_finger_count,
    output logic signed [15:0]     out_x,
    output logic signed [15:0]     out_y,
    output logic [TimeW-1:0]       out_time_us,
    output logic                   out_last
);

    logic [1:0] resp_lvl_reg;
    logic       ign_en_reg;
    logic [2:0] ign_lvl_reg;

    entry_t     cache_mem [CacheDepth];
    logic [CntW-1:0] count_reg, count_next;
    logic moved_reg, moved_next, stopped_reg, stopped_next;
    logic icpt_reg, icpt_next, sv_reg, sv_next, armed_reg, armed_next;
    entry_t sp_reg, sp_next;
    logic [TimeW-1:0] lastup_reg, lastup_next, dl_reg, dl_next;

    // captured item
    logic [2:0]       act_reg;
    entry_t           ev_reg;
    logic [TimeW-1:0] t_reg;
    op_t              op_reg, op_next;
    logic [CntW-1:0]  scan_reg;

    // decision on live input
    logic [2:0] act;
    entry_t     ev;
    logic       resp, ign, pass, near, append;
    logic [TimeW:0] dsum;
    logic signed [16:0] dx, dy;
    logic [33:0] dist_sq;

    always_comb
    begin
        act = (kind <= KIND_CANCEL) ? kind : KIND_OTHER;
        ev  = '{pointer_id, finger_count, pos_x, pos_y};
        resp = resp_lvl_reg != 2'd0;
        ign  = ign_en_reg;
        dsum = {1'b0, time_us} + {1'b0, resp_delay(resp_lvl_reg)};
        dx = 17'(signed'(sp_reg.x)) - 17'(pos_x);
        dy = 17'(signed'(sp_reg.y)) - 17'(pos_y);
        dist_sq = 34'(dx * dx) + 34'(dy * dy);
        near = (time_us < lastup_reg) ||
               ((time_us - lastup_reg) < ign_window(ign_lvl_reg));
        count_next = count_reg; moved_next = moved_reg; stopped_next = stopped_reg;
        icpt_next = icpt_reg; sv_next = sv_reg; armed_next = armed_reg;
        sp_next = sp_reg; lastup_next = lastup_reg; dl_next = dl_reg;
        op_next = OP_NONE; append = 1'b0; pass = 1'b1;
        if (kind == KIND_TICK) begin
            if (armed_reg && time_us >= dl_reg) begin
                armed_next = 1'b0; stopped_next = 1'b1; op_next = OP_REPLAY;
            end
        end else if (is_knuckle || !is_touchscreen) begin
            op_next = OP_EMIT;
        end else if (act == KIND_CANCEL) begin
            moved_next = 1'b0; icpt_next = 1'b0; sv_next = 1'b0;
        end else if (act == KIND_OTHER || (!resp && !ign)) begin
            op_next = OP_EMIT;
        end else begin
            if (ign) begin
                if (act == KIND_DOWN) begin
                    if (finger_count == 5'd1 && near) begin
                        icpt_next = 1'b1; pass = 1'b0;
                    end else if (finger_count > 5'd1 && icpt_reg) begin
                        pass = 1'b0;
                    end else begin
                        icpt_next = 1'b0;
                    end
                end else if (icpt_reg) begin
                    pass = 1'b0;
                end else if (act == KIND_UP && finger_count == 5'd1) begin
                    lastup_next = time_us;
                end
                if (pass && !resp) op_next = OP_EMIT;
            end
            if (pass && resp) begin
                if (act == KIND_DOWN) begin
                    if (finger_count > 5'd1) begin
                        if (count_reg != '0) begin
                            if (moved_reg) begin
                                append = 1'b1; op_next = OP_EMIT;
                            end else if (!stopped_reg) begin
                                append = 1'b1;
                            end
                        end
                    end else begin
                        sp_next = ev; sv_next = 1'b1; moved_next = 1'b0;
                        stopped_next = 1'b0; armed_next = 1'b1;
                        dl_next = dsum[TimeW] ? TimeMax : dsum[TimeW-1:0];
                        count_next = '0;
                        append = 1'b1;
                    end
                end else if (act == KIND_MOVE) begin
                    if (count_reg == '0) begin
                    end else if (moved_reg) begin
                        armed_next = 1'b0; op_next = OP_EMIT;
                    end else if (!sv_reg) begin
                    end else if (pointer_id != sp_reg.id) begin
                        if (stopped_reg) op_next = OP_EMIT;
                    end else if (dist_sq > SlopSq) begin
                        armed_next = 1'b0;
                        op_next = stopped_reg ? OP_EMIT : OP_REPLAY_MOVE;
                        moved_next = 1'b1; stopped_next = 1'b1;
                    end else if (stopped_reg) begin
                        op_next = OP_EMIT;
                    end
                end else begin
                    if (count_reg == '0) begin
                        armed_next = 1'b0; stopped_next = 1'b1;
                    end else if (stopped_reg) begin
                        op_next = OP_UPSCAN;
                        if (finger_count == 5'd1) count_next = '0;
                    end else if (sv_reg && pointer_id == sp_reg.id) begin
                        armed_next = 1'b0; stopped_next = 1'b1; count_next = '0;
                    end else begin
                        op_next = OP_REMOVE;
                    end
                end
            end
        end
    end

    // scan uses the count at capture time; up scan may have cleared count
    logic [CntW-1:0] scan_len_reg;
    entry_t          cur;
    logic [CacheDepth-1:0] match_vec, more_vec;
    logic [IdxW-1:0] sidx, nidx;

    assign sidx = scan_reg[IdxW-1:0];
    assign nidx = sidx + 1'b1;
    assign cur  = cache_mem[sidx];

    always_comb
    begin
        for (int i = 0; i < CacheDepth; i++)
        begin
            match_vec[i] = (cache_mem[i].id == ev_reg.id) && (CntW'(i) >= scan_reg) &&
                           (CntW'(i) < scan_len_reg);
            more_vec[i]  = (cache_mem[i].id == ev_reg.id) && (CntW'(i) > scan_reg) &&
                           (CntW'(i) < scan_len_reg);
        end
    end

    assign stat = '{op: op_reg,
                    scan_done: scan_reg >= scan_len_reg,
                    scan_hit: cur.id == ev_reg.id,
                    rest_hit: |match_vec,
                    more_hit: |more_vec,
                    scan_last: (scan_reg + 1'b1) >= scan_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_lvl_reg <= '0; ign_en_reg <= 1'b0; ign_lvl_reg <= '0;
            count_reg <= '0; moved_reg <= 1'b0; stopped_reg <= 1'b0;
            icpt_reg <= 1'b0; sv_reg <= 1'b0; armed_reg <= 1'b0;
            sp_reg <= '0; lastup_reg <= '0; dl_reg <= '0;
            op_reg <= OP_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    {1'b0, REG_RESPONSE}: resp_lvl_reg <= cfg_data[1:0];
                    {1'b0, REG_IGN_EN}:   ign_en_reg   <= cfg_data[0];
                    {1'b0, REG_IGN_LVL}:  ign_lvl_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                count_next_apply: begin
                    if (append && count_next < CntW'(CacheDepth))
                        count_reg <= count_next + 1'b1;
                    else
                        count_reg <= count_next;
                end
                moved_reg <= moved_next; stopped_reg <= stopped_next;
                icpt_reg <= icpt_next; sv_reg <= sv_next; armed_reg <= armed_next;
                sp_reg <= sp_next; lastup_reg <= lastup_next; dl_reg <= dl_next;
                op_reg <= op_next;
            end
            else if (cmd.drop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= act; ev_reg <= ev; t_reg <= time_us;
            scan_reg <= '0; scan_len_reg <= count_reg;
            if (append && count_next < CntW'(CacheDepth))
                cache_mem[count_next[IdxW-1:0]] <= ev;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        else if (cmd.shift_step)
        begin
            cache_mem[sidx] <= cache_mem[nidx];
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.emit_in || cmd.emit_up)
        begin
            out_action <= cmd.emit_up ? KIND_UP : act_reg;
            out_pointer_id <= ev_reg.id; out_finger_count <= ev_reg.fc;
            out_x <= ev_reg.x; out_y <= ev_reg.y; out_time_us <= t_reg;
            out_last <= cmd.last;
        end
        else if (cmd.emit_rep)
        begin
            out_action <= KIND_DOWN;
            out_pointer_id <= cur.id; out_finger_count <= cur.fc;
            out_x <= cur.x; out_y <= cur.y; out_time_us <= t_reg;
            out_last <= cmd.last;
        end
    end

endmodule
`default_nettype wire

/* rtl/tcdr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcdr_ctrl
// Sequencer: accepts an item, walks replay / up / remove scans, drives output.
// ----------------------------------------------------------------------------
module tcdr_ctrl import tcdr_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_REP   = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_UP    = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_PULL  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   free;

    assign free      = !ov_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.op)
                    OP_EMIT:
                        if (free)
                        begin
                            cmd.emit_in = 1'b1; cmd.last = 1'b1; ov_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    OP_REPLAY:      state_next = S_REP;
                    OP_REPLAY_MOVE: state_next = S_MOVE;
                    OP_UPSCAN:      state_next = S_UP;
                    OP_REMOVE:      state_next = S_SHIFT;
                    default:        state_next = S_IDLE;
                endcase
            end
            S_REP, S_MOVE:
            begin
                if (stat.scan_done)
                begin
                    if (state_reg == S_MOVE)
                    begin
                        if (free)
                        begin
                            cmd.emit_in = 1'b1; cmd.last = 1'b1; ov_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                        state_next = S_IDLE;
                end
                else if (free)
                begin
                    cmd.emit_rep = 1'b1; cmd.scan_step = 1'b1; ov_next = 1'b1;
                    cmd.last = (state_reg == S_REP) && stat.scan_last;
                    state_next = state_reg;
                end
            end
            S_UP:
            begin
                if (stat.scan_done || !stat.rest_hit)
                    state_next = S_IDLE;
                else if (!stat.scan_hit)
                    cmd.scan_step = 1'b1;
                else if (free)
                begin
                    cmd.emit_up = 1'b1; cmd.scan_step = 1'b1; ov_next = 1'b1;
                    cmd.last = !stat.more_hit;
                end
            end
            S_SHIFT:
            begin
                if (stat.scan_done)
                    state_next = S_IDLE;
                else if (!stat.scan_hit)
                    cmd.scan_step = 1'b1;
                else
                    state_next = S_PULL;
            end
            S_PULL:
            begin
                if (stat.scan_last)
                begin
                    cmd.drop = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/touch_click_delay_repeat_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// touch_click_delay_repeat_filter
// Accessibility touch filter: repeat-click drop and click response delay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event or tick per transfer.
//   Output channel (out_valid/out_ready) carries forwarded or replayed
//   events; out_last marks the final result of an input item. Items with no
//   result give no output transfer.
//   Configuration: cfg_we/cfg_index/cfg_data, one write per cycle, only while
//   the block is idle.
//   An input item is captured with its decision; each result is then
//   registered in the output register. A new item is taken only once the
//   previous item is done. Replay, up scan and remove walk the cache one
//   entry per cycle, an entry that gives a result waiting while the output
//   is stalled.
//   Reset clears all control state, timer and cache count; cache contents
//   are not cleared. A stalled receiver holds the output register and the
//   sequencer waits, adding the stall cycles to the item.
// ----------------------------------------------------------------------------
module touch_click_delay_repeat_filter import tcdr_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [2:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        kind,
    input  wire logic [7:0]        pointer_id,
    input  wire logic [4:0]        finger_count,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic [TimeW-1:0]  time_us,
    input  wire logic              is_knuckle,
    input  wire logic              is_touchscreen,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             out_action,
    output logic [7:0]             out_pointer_id,
    output logic [4:0]             out_finger_count,
    output logic signed [15:0]     out_x,
    output logic signed [15:0]     out_y,
    output logic [TimeW-1:0]       out_time_us,
    output logic                   out_last
);

    cmd_t  cmd;
    stat_t stat;

    tcdr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd)
    );

    tcdr_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index({1'b0, cfg_index}), .cfg_data(cfg_data),
        .kind(kind), .pointer_id(pointer_id), .finger_count(finger_count),
        .pos_x(pos_x), .pos_y(pos_y), .time_us(time_us),
        .is_knuckle(is_knuckle), .is_touchscreen(is_touchscreen),
        .cmd(cmd), .stat(stat),
        .out_action(out_action), .out_pointer_id(out_pointer_id),
        .out_finger_count(out_finger_count), .out_x(out_x), .out_y(out_y),
        .out_time_us(out_time_us), .out_last(out_last)
    );

endmodule
`default_nettype wire

/* tb/touch_click_delay_repeat_filter_test.sv */
// ----------------------------------------------------------------------------
// touch_click_delay_repeat_filter_test
// Self-checking bench for the click delay / repeat filter. Directed and random
// event streams go in over valid/ready; each output transfer is compared with
// a behavioral prediction of the filter kept alongside.
// ----------------------------------------------------------------------------
module touch_click_delay_repeat_filter_test;
    import tcdr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  id;
        logic [4:0]  fc;
        logic [15:0] x;
        logic [15:0] y;
        logic [47:0] t;
        logic        last;
    } event_t;

    localparam int WatchLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] kind = '0;
    logic [7:0] pointer_id = '0;
    logic [4:0] finger_count = 5'd1;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [47:0] time_us = '0;
    logic is_knuckle = 1'b0;
    logic is_touchscreen = 1'b1;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] out_action;
    logic [7:0] out_pointer_id;
    logic [4:0] out_finger_count;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [47:0] out_time_us;
    logic out_last;

    touch_click_delay_repeat_filter u_dut (.*);

    always #4 clk = ~clk;

    // predictor state
    logic [1:0] m_resp;
    logic m_ign_en;
    logic [2:0] m_ign_lvl;
    entry_t m_cache [CacheDepth];
    int m_count;
    bit m_moved, m_stopped, m_icpt, m_start_ok, m_armed;
    logic [7:0] m_sp_id;
    logic [15:0] m_sp_x, m_sp_y;
    logic [47:0] m_last_up, m_deadline;

    event_t expected_events [$];
    int errors = 0;
    bit quiet = 1'b0;       // when set, sender-side idling is off
    bit rx_quiet = 1'b0;
    int idle_cycles = 0;
    logic [47:0] now = 48'd1000;

    task automatic push_event(input logic [2:0] a, input entry_t e, input logic [47:0] t);
        event_t ev;
        ev = {a, e.id, e.fc, e.x, e.y, t, 1'b0};
        expected_events.insert(expected_events.size(), ev);
    endtask

    task automatic replay_cache(input logic [47:0] t);
        for (int i = 0; i < m_count; i++)
            push_event(KIND_DOWN, m_cache[i], t);
    endtask

    task automatic cache_add(input entry_t e);
        if (m_count < CacheDepth)
        begin
            m_cache[m_count] = e;
            m_count++;
        end
    endtask

    task automatic predict_filter(input logic [2:0] k, input entry_t e, input logic [47:0] t,
                                  input bit knk, input bit ts);
        int base;
        logic [2:0] a;
        bit pass;
        bit near;
        longint dx, dy;
        logic [48:0] d;
        base = expected_events.size();
        a = (k <= 3) ? k : KIND_OTHER;
        pass = 1'b1;
        if (k == KIND_TICK)
        begin
            if (m_armed && t >= m_deadline)
            begin
                m_armed = 0;
                m_stopped = 1;
                replay_cache(t);
            end
        end
        else if (knk || !ts)
            push_event(a, e, t);
        else if (a == KIND_CANCEL)
        begin
            m_moved = 0;
            m_icpt = 0;
            m_start_ok = 0;
        end
        else if (a == KIND_OTHER || (m_resp == 0 && !m_ign_en))
            push_event(a, e, t);
        else
        begin
            if (m_ign_en)
            begin
                if (a == KIND_DOWN)
                begin
                    near = (t < m_last_up) || (t - m_last_up < ign_window(m_ign_lvl));
                    if (e.fc == 1 && near)
                    begin
                        m_icpt = 1;
                        pass = 0;
                    end
                    else if (e.fc > 1 && m_icpt)
                        pass = 0;
                    else
                        m_icpt = 0;
                end
                else if (m_icpt)
                    pass = 0;
                else if (a == KIND_UP && e.fc == 1)
                    m_last_up = t;
                if (pass && m_resp == 0)
                    push_event(a, e, t);
            end
            if (pass && m_resp != 0)
            begin
                if (a == KIND_DOWN)
                begin
                    if (e.fc > 1)
                    begin
                        if (m_count != 0)
                        begin
                            if (m_moved)
                            begin
                                cache_add(e);
                                push_event(KIND_DOWN, e, t);
                            end
                            else if (!m_stopped)
                                cache_add(e);
                        end
                    end
                    else
                    begin
                        d = {1'b0, t} + {1'b0, resp_delay(m_resp)};
                        m_sp_id = e.id;
                        m_sp_x = e.x;
                        m_sp_y = e.y;
                        m_start_ok = 1;
                        m_moved = 0;
                        m_stopped = 0;
                        m_count = 0;
                        cache_add(e);
                        m_armed = 1;
                        m_deadline = d[48] ? TimeMax : d[47:0];
                    end
                end
                else if (a == KIND_MOVE)
                begin
                    if (m_count == 0)
                        ;
                    else if (m_moved)
                    begin
                        m_armed = 0;
                        push_event(KIND_MOVE, e, t);
                    end
                    else if (!m_start_ok)
                        ;
                    else if (e.id != m_sp_id)
                    begin
                        if (m_stopped)
                            push_event(KIND_MOVE, e, t);
                    end
                    else
                    begin
                        dx = longint'($signed(m_sp_x)) - longint'($signed(e.x));
                        dy = longint'($signed(m_sp_y)) - longint'($signed(e.y));
                        if (dx * dx + dy * dy > 64)
                        begin
                            m_armed = 0;
                            if (!m_stopped)
                                replay_cache(t);
                            push_event(KIND_MOVE, e, t);
                            m_moved = 1;
                            m_stopped = 1;
                        end
                        else if (m_stopped)
                            push_event(KIND_MOVE, e, t);
                    end
                end
                else
                begin
                    if (m_count == 0)
                    begin
                        m_armed = 0;
                        m_stopped = 1;
                    end
                    else if (m_stopped)
                    begin
                        for (int i = 0; i < m_count; i++)
                            if (m_cache[i].id == e.id)
                                push_event(KIND_UP, e, t);
                        if (e.fc == 1)
                            m_count = 0;
                    end
                    else if (m_start_ok && e.id == m_sp_id)
                    begin
                        m_armed = 0;
                        m_stopped = 1;
                        m_count = 0;
                    end
                    else
                    begin
                        for (int i = 0; i < m_count; i++)
                            if (m_cache[i].id == e.id)
                            begin
                                for (int j = i; j + 1 < m_count; j++)
                                    m_cache[j] = m_cache[j + 1];
                                m_count--;
                                break;
                            end
                    end
                end
            end
        end
        if (expected_events.size() > base)
            expected_events[$].last = 1'b1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RESPONSE: m_resp = val[1:0];
            REG_IGN_EN:   m_ign_en = val[0];
            default:      m_ign_lvl = val;
        endcase
    endtask

    task automatic drain_results;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (2 * CacheDepth + 8) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] r, input bit ie, input logic [2:0] il);
        drain_results();
        write_reg(REG_RESPONSE, {1'b0, r});
        write_reg(REG_IGN_EN, {2'b0, ie});
        write_reg(REG_IGN_LVL, il);
    endtask

    task automatic send_item(input logic [2:0] k, input logic [7:0] id, input logic [4:0] fc,
                             input logic [15:0] x, input logic [15:0] y, input logic [47:0] t,
                             input bit knk = 1'b0, input bit ts = 1'b1);
        entry_t e;
        e = '{id: id, fc: fc, x: x, y: y};
        @(posedge clk);
        while (!quiet && $urandom_range(99) < 18)
            @(posedge clk);
        in_valid <= 1'b1;
        kind <= k;
        pointer_id <= id;
        finger_count <= fc;
        pos_x <= x;
        pos_y <= y;
        time_us <= t;
        is_knuckle <= knk;
        is_touchscreen <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_filter(k, e, t, knk, ts);
        in_valid <= 1'b0;
    endtask

    // results checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            event_t got, want;
            got = {out_action, out_pointer_id, out_finger_count, out_x, out_y,
                   out_time_us, out_last};
            if (expected_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %h", got);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected a%0d id%0d fc%0d x%h y%h t%h l%b, got a%0d id%0d fc%0d x%h y%h t%h l%b",
                                 want.action, want.id, want.fc, want.x, want.y, want.t, want.last,
                                 got.action, got.id, got.fc, got.x, got.y, got.t, got.last);
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_passthrough;
        configure(2'd0, 1'b0, 3'd0);
        send_item(KIND_DOWN, 8'hFF, 5'd16, 16'h7FFF, 16'h8000, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_OTHER, 8'h00, 5'd0, 16'h8000, 16'h7FFF, 48'h0);
        send_item(3'd6, 8'h55, 5'd1, 16'h1, 16'h2, now);
        send_item(3'd7, 8'hAA, 5'd31, 16'hFFFF, 16'h0, now);
        send_item(KIND_CANCEL, 8'h1, 5'd1, 0, 0, now, 1'b1, 1'b1);
        send_item(KIND_UP, 8'h2, 5'd1, 0, 0, now, 1'b0, 1'b0);
        send_item(KIND_CANCEL, 8'h2, 5'd1, 0, 0, now);
        send_item(KIND_TICK, 8'h0, 5'd1, 0, 0, now);
    endtask

    task automatic test_repeat_drop;
        configure(2'd0, 1'b1, 3'd4);
        now = 48'd5_000_000;
        send_item(KIND_DOWN, 8'd1, 5'd1, 10, 10, now);
        send_item(KIND_UP, 8'd1, 5'd1, 10, 10, now + 1000);
        send_item(KIND_DOWN, 8'd1, 5'd1, 10, 10, now + 200_000);
        send_item(KIND_DOWN, 8'd2, 5'd2, 10, 10, now + 200_100);
        send_item(KIND_MOVE, 8'd1, 5'd1, 90, 10, now + 200_200);
        send_item(KIND_DOWN, 8'd1, 5'd0, 10, 10, now + 300_000);
        send_item(KIND_DOWN, 8'd1, 5'd1, 10, 10, now - 5);
        now = now + 3_000_000;
    endtask

    task automatic test_delay;
        configure(2'd3, 1'b0, 3'd7);
        send_item(KIND_DOWN, 8'd4, 5'd1, 0, 0, 48'hFFFF_FFFF_FF00);
        send_item(KIND_TICK, 0, 1, 0, 0, 48'hFFFF_FFFF_FF00);
        configure(2'd2, 1'b0, 3'd0);
        send_item(KIND_DOWN, 8'd4, 5'd1, 0, 0, 48'hFFFF_FFFF_FF00);
        for (int i = 0; i < 17; i++)
            send_item(KIND_DOWN, 8'(i + 5), 5'd2, 16'(i), 0, 48'hFFFF_FFFF_FF01);
        send_item(KIND_TICK, 0, 1, 0, 0, 48'hFFFF_FFFF_FFFE);
        send_item(KIND_TICK, 0, 1, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_UP, 8'd5, 5'd2, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_UP, 8'd4, 5'd1, 0, 0, 48'hFFFF_FFFF_FFFF);
    endtask

    task automatic test_pause;
        quiet = 1'b1;
        send_item(KIND_OTHER, 8'd9, 5'd1, 0, 0, now);
        while (expected_events.size() != 0)
            @(posedge clk);
        quiet = 1'b0;
    endtask

    task automatic random_gesture;
        logic [7:0] id0;
        logic [15:0] x0, y0;
        int n;
        id0 = 8'($urandom);
        x0 = 16'($urandom);
        y0 = 16'($urandom);
        now = now + 48'($urandom_range(2_000_000));
        if ($urandom_range(9) == 0)
            now = 48'($urandom) | (48'($urandom) << 16);
        send_item(KIND_DOWN, id0, 5'd1, x0, y0, now);
        n = $urandom_range(4);
        for (int i = 0; i < n; i++)
        begin
            now = now + 48'($urandom_range(50_000));
            case ($urandom_range(5))
                0: send_item(KIND_DOWN, 8'($urandom_range(7)), 5'($urandom_range(2, 16)),
                             16'($urandom), 16'($urandom), now);
                1: send_item(KIND_MOVE, id0, 5'd1, x0 + 16'($urandom_range(12)) - 16'd6,
                             y0 + 16'($urandom_range(20)) - 16'd10, now);
                2: send_item(KIND_MOVE, 8'($urandom_range(7)), 5'd2, 16'($urandom),
                             16'($urandom), now);
                3: send_item(KIND_TICK, 0, 1, 0, 0, now + 48'($urandom_range(700_000)));
                4: send_item(KIND_UP, 8'($urandom_range(7)), 5'($urandom_range(1, 3)),
                             x0, y0, now);
                default: send_item(3'($urandom), 8'($urandom), 5'($urandom), 16'($urandom),
                                   16'($urandom), 48'($urandom), 1'($urandom), 1'($urandom));
            endcase
        end
        if ($urandom_range(3) == 0)
            send_item(KIND_CANCEL, id0, 5'd1, x0, y0, now);
        send_item(KIND_UP, id0, 5'd1, x0, y0, now + 48'($urandom_range(100_000)));
    endtask

    task automatic test_random;
        for (int p = 0; p < 6; p++)
        begin
            configure(2'(p % 3), 1'(p / 2), 3'(p == 5 ? 7 : p));
            rx_quiet = (p == 2);
            quiet = (p == 2);
            for (int g = 0; g < 5; g++)
                random_gesture();
        end
        rx_quiet = 1'b0;
        quiet = 1'b0;
    endtask

    initial
    begin
        m_resp = 0;
        m_ign_en = 0;
        m_ign_lvl = 0;
        m_count = 0;
        {m_moved, m_stopped, m_icpt, m_start_ok, m_armed} = '0;
        m_sp_id = 0;
        m_sp_x = 0;
        m_sp_y = 0;
        m_last_up = 0;
        m_deadline = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_passthrough();
        test_repeat_drop();
        test_delay();
        test_pause();
        test_random();
        drain_results();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* touch_click_delay_repeat_filter.f */
rtl/tcdr_pkg.sv
rtl/tcdr_datapath.sv
rtl/tcdr_ctrl.sv
rtl/touch_click_delay_repeat_filter.sv
tb/touch_click_delay_repeat_filter_test.sv
